// ===== rtl/core/memory_command_multi_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the memory command multi-queue
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef MEMORY_COMMAND_MULTI_QUEUE_MACROS_SVH
`define MEMORY_COMMAND_MULTI_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MCMQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MCMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mcmq_pkg.sv =====
// ---------------------------------------------------------------------------
// mcmq_pkg
// Sizes, codes and shared types of the memory command multi-queue.
// ---------------------------------------------------------------------------
package mcmq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH    = 16;
    localparam int NUM_REQUESTORS = 8;
    localparam int SHARED_QUEUES  = 2;
    localparam int NUM_QUEUES     = SHARED_QUEUES + 2 * NUM_REQUESTORS;
    localparam int RAM_DEPTH      = NUM_QUEUES * QUEUE_DEPTH;

    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W   = $clog2(NUM_QUEUES);
    localparam int REQ_ID_W = $clog2(NUM_REQUESTORS);
    localparam int OLEN_W   = $clog2(NUM_REQUESTORS + 1);
    localparam int RAM_AW   = $clog2(RAM_DEPTH);

    // Field widths of the stream items
    localparam int TAG_W      = 32;
    localparam int SEL_W      = 3;
    localparam int POS_W      = 4;
    localparam int QCOUNT_W   = 5;
    localparam int RCOUNT_W   = 4;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;
    localparam int RCOUNT_MAX = 15;

    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [SEL_W-1:0]    sel_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [QCOUNT_W-1:0] qcount_t;
    typedef logic [RCOUNT_W-1:0] rcount_t;
    typedef logic [QPTR_W-1:0]   qptr_t;
    typedef logic [QPTR_W:0]     psum_t;
    typedef logic [QCNT_W-1:0]   qcnt_t;
    typedef logic [QIDX_W-1:0]   qidx_t;
    typedef logic [REQ_ID_W-1:0] req_id_t;
    typedef logic [OLEN_W-1:0]   olen_t;
    typedef logic [RAM_AW-1:0]   ram_addr_t;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_GEN_FRONT = 3'd1,
        ACT_GEN_PEEK  = 3'd2,
        ACT_REQ_FRONT = 3'd3,
        ACT_SLOT_PEEK = 3'd4,
        ACT_REQ_POP   = 3'd5,
        ACT_GEN_POP   = 3'd6,
        ACT_SIZES     = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BEYOND = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/core/mcmq_ram.sv =====
// ---------------------------------------------------------------------------
// mcmq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module mcmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mcmq_ctrl.sv =====
// ---------------------------------------------------------------------------
// mcmq_ctrl
// Sequencer: capture one item, execute it, publish its result.
// ---------------------------------------------------------------------------
module mcmq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output mcmq_pkg::dp_cmd_t cmd,
    input  mcmq_pkg::dp_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tready_reg && s_tvalid) begin
                        state_reg    <= S_EXEC;
                        s_tready_reg <= 1'b0;
                    end else begin
                        s_tready_reg <= 1'b1;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register can take the result
                    if (sts.out_free) begin
                        state_reg    <= S_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= S_IDLE;
                    s_tready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready    = s_tready_reg;
    assign cmd.capture = s_tready_reg && s_tvalid;
    assign cmd.execute = (state_reg == S_EXEC);
    assign cmd.publish = (state_reg == S_FIN) && sts.out_free;

endmodule

// ===== rtl/core/mcmq_dp.sv =====
// ---------------------------------------------------------------------------
// mcmq_dp
// Queue pointers, order list, tag RAM and output register.
// ---------------------------------------------------------------------------
`include "memory_command_multi_queue_macros.svh"

module mcmq_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mcmq_pkg::dp_cmd_t                   cmd,
    output mcmq_pkg::dp_sts_t                   sts,
    input  logic [mcmq_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mcmq_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic                                cfg_data
);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_PEEK,
        OP_POP,
        OP_COUNT
    } op_t;

    // captured item
    mcmq_pkg::action_t act_reg;
    mcmq_pkg::tag_t    tag_reg;
    mcmq_pkg::sel_t    sel_reg;
    logic              crit_reg;
    logic              rt_reg;
    mcmq_pkg::pos_t    pos_reg;

    // queue state
    mcmq_pkg::qptr_t   head_reg  [mcmq_pkg::NUM_QUEUES];
    mcmq_pkg::qcnt_t   count_reg [mcmq_pkg::NUM_QUEUES];
    mcmq_pkg::req_id_t list_reg  [mcmq_pkg::NUM_REQUESTORS];
    mcmq_pkg::olen_t   order_len_reg;
    logic              sel_shared_reg;
    logic              layout_reg;

    // result of the execute step
    mcmq_pkg::qcount_t res_count_reg;
    mcmq_pkg::rcount_t res_len_reg;
    mcmq_pkg::status_t res_status_reg;
    logic              res_read_reg;

    // output register
    logic              m_tvalid_reg;
    mcmq_pkg::tag_t    out_tag_reg;
    mcmq_pkg::qcount_t out_count_reg;
    mcmq_pkg::rcount_t out_len_reg;
    mcmq_pkg::status_t out_status_reg;

    // execute decode
    op_t                 op;
    mcmq_pkg::status_t   pre_st;
    mcmq_pkg::status_t   st;
    mcmq_pkg::qidx_t     q;
    mcmq_pkg::pos_t      rd_pos;
    mcmq_pkg::req_id_t   req_id;
    mcmq_pkg::req_id_t   list_id;
    mcmq_pkg::qidx_t     shared_q;
    mcmq_pkg::qidx_t     req_q;
    mcmq_pkg::qidx_t     list_q;
    mcmq_pkg::olen_t     len_eff;
    mcmq_pkg::qcnt_t     cnt;
    mcmq_pkg::qptr_t     head;
    mcmq_pkg::qcnt_t     count_next;
    mcmq_pkg::qptr_t     head_next;
    mcmq_pkg::olen_t     order_len_next;
    mcmq_pkg::psum_t     slot_sum;
    mcmq_pkg::qptr_t     slot;
    logic                id_ok;
    logic                slot_ok;
    logic                fill;
    logic                do_push;
    logic                do_pop;
    logic                do_read;
    logic                set_sel;
    logic                found;
    logic                append;

    mcmq_pkg::ram_addr_t ram_addr;
    mcmq_pkg::tag_t      ram_rd_data;
    logic                ram_wr_en;
    logic                ram_rd_en;

    always_comb begin
        req_id   = mcmq_pkg::req_id_t'(sel_reg);
        id_ok    = int'(sel_reg) < mcmq_pkg::NUM_REQUESTORS;
        shared_q = mcmq_pkg::qidx_t'(crit_reg);
        req_q    = mcmq_pkg::qidx_t'(mcmq_pkg::SHARED_QUEUES
                   + int'(rt_reg) * mcmq_pkg::NUM_REQUESTORS + int'(req_id));
        // lazy fill of an empty order list: slot n lists requestor n
        fill     = (act_reg == mcmq_pkg::ACT_SIZES) && layout_reg && (order_len_reg == '0);
        len_eff  = fill ? mcmq_pkg::olen_t'(mcmq_pkg::NUM_REQUESTORS) : order_len_reg;
        slot_ok  = int'(sel_reg) < int'(len_eff);
        list_id  = fill ? req_id : list_reg[req_id];
        list_q   = mcmq_pkg::qidx_t'(mcmq_pkg::SHARED_QUEUES
                   + int'(rt_reg) * mcmq_pkg::NUM_REQUESTORS + int'(list_id));

        op      = OP_NONE;
        pre_st  = mcmq_pkg::ST_OK;
        q       = '0;
        rd_pos  = '0;
        set_sel = 1'b0;

        case (act_reg)
            mcmq_pkg::ACT_INSERT: begin
                if (!layout_reg) begin
                    q  = shared_q;
                    op = OP_PUSH;
                end else if (id_ok) begin
                    q  = req_q;
                    op = OP_PUSH;
                end else begin
                    pre_st = mcmq_pkg::ST_FULL;
                end
            end
            mcmq_pkg::ACT_GEN_FRONT: begin
                set_sel = 1'b1;
                q       = shared_q;
                op      = OP_PEEK;
            end
            mcmq_pkg::ACT_GEN_PEEK: begin
                q      = shared_q;
                op     = OP_PEEK;
                rd_pos = pos_reg;
            end
            mcmq_pkg::ACT_REQ_FRONT: begin
                if (id_ok) begin
                    q  = req_q;
                    op = OP_PEEK;
                end else begin
                    pre_st = mcmq_pkg::ST_EMPTY;
                end
            end
            mcmq_pkg::ACT_REQ_POP: begin
                if (id_ok) begin
                    q  = req_q;
                    op = OP_POP;
                end else begin
                    pre_st = mcmq_pkg::ST_EMPTY;
                end
            end
            mcmq_pkg::ACT_SLOT_PEEK: begin
                if (slot_ok) begin
                    q      = list_q;
                    op     = OP_PEEK;
                    rd_pos = pos_reg;
                end else begin
                    pre_st = mcmq_pkg::ST_BEYOND;
                end
            end
            mcmq_pkg::ACT_SIZES: begin
                if (!layout_reg) begin
                    q  = shared_q;
                    op = OP_COUNT;
                end else if (slot_ok) begin
                    q  = list_q;
                    op = OP_COUNT;
                end else begin
                    pre_st = mcmq_pkg::ST_BEYOND;
                end
            end
            default: begin
                q  = mcmq_pkg::qidx_t'(sel_shared_reg);
                op = OP_POP;
            end
        endcase

        cnt     = count_reg[q];
        head    = head_reg[q];
        st      = mcmq_pkg::ST_OK;
        do_push = 1'b0;
        do_pop  = 1'b0;
        do_read = 1'b0;

        case (op)
            OP_PUSH: begin
                if (int'(cnt) >= mcmq_pkg::QUEUE_DEPTH) begin
                    st = mcmq_pkg::ST_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            OP_PEEK: begin
                if (cnt == '0) begin
                    st = mcmq_pkg::ST_EMPTY;
                end else if (int'(rd_pos) >= int'(cnt)) begin
                    st = mcmq_pkg::ST_BEYOND;
                end else begin
                    do_read = 1'b1;
                end
            end
            OP_POP: begin
                if (cnt == '0) begin
                    st = mcmq_pkg::ST_EMPTY;
                end else begin
                    do_pop = 1'b1;
                end
            end
            OP_COUNT: begin
                st = mcmq_pkg::ST_OK;
            end
            default: begin
                st = pre_st;
            end
        endcase

        if (do_push) begin
            count_next = cnt + 1'b1;
        end else if (do_pop) begin
            count_next = cnt - 1'b1;
        end else begin
            count_next = cnt;
        end

        head_next = (int'(head) + 1 == mcmq_pkg::QUEUE_DEPTH) ? '0 : head + 1'b1;

        // ring slot: head plus fill level on insert, plus offset on read
        slot_sum = mcmq_pkg::psum_t'(head)
                 + (do_push ? mcmq_pkg::psum_t'(cnt) : mcmq_pkg::psum_t'(rd_pos));
        if (int'(slot_sum) >= mcmq_pkg::QUEUE_DEPTH) begin
            slot = mcmq_pkg::qptr_t'(int'(slot_sum) - mcmq_pkg::QUEUE_DEPTH);
        end else begin
            slot = mcmq_pkg::qptr_t'(slot_sum);
        end
    end

    // order list: record each requestor once, on its first accepted insert
    always_comb begin
        found = 1'b0;
        for (int i = 0; i < mcmq_pkg::NUM_REQUESTORS; i++) begin
            if (i < int'(order_len_reg) && list_reg[i] == req_id) begin
                found = 1'b1;
            end
        end
        append = do_push && layout_reg && (act_reg == mcmq_pkg::ACT_INSERT)
               && !found && (int'(order_len_reg) < mcmq_pkg::NUM_REQUESTORS);
        if (fill) begin
            order_len_next = mcmq_pkg::olen_t'(mcmq_pkg::NUM_REQUESTORS);
        end else if (append) begin
            order_len_next = order_len_reg + 1'b1;
        end else begin
            order_len_next = order_len_reg;
        end
    end

    assign ram_addr  = mcmq_pkg::ram_addr_t'(int'(q) * mcmq_pkg::QUEUE_DEPTH + int'(slot));
    assign ram_wr_en = cmd.execute && do_push;
    assign ram_rd_en = cmd.execute && do_read;

    mcmq_ram #(
        .WIDTH (mcmq_pkg::TAG_W),
        .DEPTH (mcmq_pkg::RAM_DEPTH)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (tag_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    // control and queue state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mcmq_pkg::NUM_QUEUES; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            order_len_reg  <= '0;
            sel_shared_reg <= 1'b1;
            layout_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                layout_reg <= cfg_data;
            end
            if (cmd.execute) begin
                count_reg[q]  <= count_next;
                order_len_reg <= order_len_next;
                if (do_pop) begin
                    head_reg[q] <= head_next;
                end
                if (set_sel) begin
                    sel_shared_reg <= crit_reg;
                end
            end
            if (cmd.publish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= mcmq_pkg::action_t'(s_tdata[2:0]);
            tag_reg  <= s_tdata[34:3];
            sel_reg  <= s_tdata[37:35];
            crit_reg <= s_tdata[38];
            rt_reg   <= s_tdata[39];
            pos_reg  <= s_tdata[43:40];
        end
        if (cmd.execute) begin
            if (fill) begin
                for (int i = 0; i < mcmq_pkg::NUM_REQUESTORS; i++) begin
                    list_reg[i] <= mcmq_pkg::req_id_t'(i);
                end
            end else if (append) begin
                list_reg[order_len_reg[mcmq_pkg::REQ_ID_W-1:0]] <= req_id;
            end
            res_count_reg  <= (op == OP_NONE) ? '0 : mcmq_pkg::qcount_t'(count_next);
            res_len_reg    <= (int'(order_len_next) > mcmq_pkg::RCOUNT_MAX)
                              ? mcmq_pkg::rcount_t'(mcmq_pkg::RCOUNT_MAX)
                              : mcmq_pkg::rcount_t'(order_len_next);
            res_status_reg <= st;
            res_read_reg   <= do_read;
        end
        if (cmd.publish) begin
            out_tag_reg    <= res_read_reg ? ram_rd_data : '0;
            out_count_reg  <= res_count_reg;
            out_len_reg    <= res_len_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = {5'd0, out_status_reg, out_len_reg, out_count_reg, out_tag_reg};

    `MCMQ_ASSERT_NEXT(a_publish_sets_valid, cmd.publish, m_tvalid_reg, "result lost on publish")
    `MCMQ_ASSERT_IMPL(a_publish_into_free, cmd.publish, !m_tvalid_reg || m_tready, "output overwritten")
    `MCMQ_ASSERT_IMPL(a_ram_one_access, cmd.execute, !(ram_wr_en && ram_rd_en), "RAM read and write together")
    `MCMQ_ASSERT_IMPL(a_order_len_bound, 1'b1, int'(order_len_reg) <= mcmq_pkg::NUM_REQUESTORS, "order list overrun")

endmodule

// ===== rtl/core/memory_command_multi_queue.sv =====
// Memory command multi-queue: command buffer of a memory controller.
// Input transfers arrive on the s_ stream (s_tvalid/s_tready/s_tdata); each
// one carries an action (insert, front, peek, pop or size query) and gives
// exactly one result transfer on the m_ stream (m_tvalid/m_tready/m_tdata).
// The layout register is written on the cfg channel (cfg_valid/cfg_ready/
// cfg_data), which is always ready; write it only while the block is idle.
// A result becomes valid once the sequencer has executed its item and
// published it; the tag RAM read is registered, and no new item is taken
// before the last has passed the capture, execute and publish steps.
// The next item is accepted while a result still waits in the output
// register; if the receiver holds m_tready low, the following result waits
// in the publish step and s_tready stays low until the output register
// frees up. Reset (aresetn low, synchronous) empties every queue and the
// order list, selects the critical shared queue for the general pop and
// sets the shared layout; the tag RAM needs no clearing pass, since only
// entries inside a queue's valid part are ever read.
// ---------------------------------------------------------------------------
// memory_command_multi_queue
// Top level: sequencer plus queue datapath.
// ---------------------------------------------------------------------------
module memory_command_multi_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata, from bit 0: action[2:0], cmd_tag[31:0], requestor_sel[2:0],
    // critical, rt_mode, position[3:0], zero fill
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mcmq_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata, from bit 0: out_tag[31:0], queue_count[4:0],
    // requestor_count[3:0], status[1:0], zero fill
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mcmq_pkg::M_TDATA_W-1:0]     m_tdata,
    // layout register: 1 per-requestor queues, 0 shared queues
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data
);

    mcmq_pkg::dp_cmd_t cmd;
    mcmq_pkg::dp_sts_t sts;

    // the register write is a single-cycle transfer: never stall it
    assign cfg_ready = 1'b1;

    // sequencer: capture, execute, publish
    mcmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // queues, order list, tag RAM and output register
    mcmq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data)
    );

endmodule

// ===== tb/tb_memory_command_multi_queue.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_memory_command_multi_queue
// Self-checking bench: drives command transfers, predicts each result with
// an independent queue model and checks every result transfer field by field.
// ---------------------------------------------------------------------------
module tb_memory_command_multi_queue;
    import mcmq_pkg::*;

    // Generous ceiling on run length, in clock cycles
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to let pass once every result has come back
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;

    // Input transfer, last field in the lowest bits
    typedef struct packed {
        logic [3:0] zero_fill;
        pos_t       pos;
        logic       rt;
        logic       crit;
        sel_t       sel;
        tag_t       tag;
        action_t    act;
    } command_t;

    // Result transfer, last field in the lowest bits
    typedef struct packed {
        logic [4:0] zero_fill;
        status_t    status;
        rcount_t    rcount;
        qcount_t    qcount;
        tag_t       tag;
    } result_t;

    // -----------------------------------------------------------------------
    // Scoreboard: shadow copy of every queue and of the order list, plus the
    // results still owed by the block.
    // -----------------------------------------------------------------------
    class cmd_queue_scoreboard;
        tag_t    slots [NUM_QUEUES][QUEUE_DEPTH];
        int      head [NUM_QUEUES];
        int      fill [NUM_QUEUES];
        sel_t    order_ids [NUM_REQUESTORS];
        int      order_len;
        logic    selected_critical;
        logic    layout_by_requestor;
        result_t expected_results [$];
        int      mismatches;

        function new();
            foreach (fill[i]) begin
                head[i] = 0;
                fill[i] = 0;
                foreach (slots[i][j]) slots[i][j] = '0;
            end
            foreach (order_ids[i]) order_ids[i] = '0;
            order_len           = 0;
            selected_critical   = 1'b1;
            layout_by_requestor = 1'b0;
            mismatches          = 0;
        endfunction

        function int requestor_queue(sel_t id, logic rt);
            return SHARED_QUEUES + int'(rt) * NUM_REQUESTORS + int'(id);
        endfunction

        function status_t push(int q, tag_t t);
            if (fill[q] >= QUEUE_DEPTH) return ST_FULL;
            slots[q][(head[q] + fill[q]) % QUEUE_DEPTH] = t;
            fill[q]++;
            return ST_OK;
        endfunction

        function status_t peek(int q, int pos, output tag_t t);
            t = '0;
            if (fill[q] == 0) return ST_EMPTY;
            if (pos >= fill[q]) return ST_BEYOND;
            t = slots[q][(head[q] + pos) % QUEUE_DEPTH];
            return ST_OK;
        endfunction

        function status_t pop(int q);
            if (fill[q] == 0) return ST_EMPTY;
            head[q] = (head[q] + 1) % QUEUE_DEPTH;
            fill[q]--;
            return ST_OK;
        endfunction

        // each requestor is listed once, in first-seen order
        function void note_requestor(sel_t id);
            for (int i = 0; i < order_len; i++)
                if (order_ids[i] == id) return;
            if (order_len < NUM_REQUESTORS) begin
                order_ids[order_len] = id;
                order_len++;
            end
        endfunction

        // Every id the 3-bit selector can name is a valid requestor
        function result_t predict(command_t c);
            result_t r;
            tag_t    t;
            int      q;
            bit      has_q;
            r     = '0;
            t     = '0;
            q     = 0;
            has_q = 1'b0;
            r.status = ST_OK;
            case (c.act)
                ACT_INSERT: begin
                    if (layout_by_requestor) begin
                        q = requestor_queue(c.sel, c.rt);
                        if (fill[q] < QUEUE_DEPTH) note_requestor(c.sel);
                    end else begin
                        q = int'(c.crit);
                    end
                    has_q    = 1'b1;
                    r.status = push(q, c.tag);
                end
                ACT_GEN_FRONT: begin
                    selected_critical = c.crit;
                    q        = int'(c.crit);
                    has_q    = 1'b1;
                    r.status = peek(q, 0, t);
                end
                ACT_GEN_PEEK: begin
                    q        = int'(c.crit);
                    has_q    = 1'b1;
                    r.status = peek(q, int'(c.pos), t);
                end
                ACT_REQ_FRONT: begin
                    q        = requestor_queue(c.sel, c.rt);
                    has_q    = 1'b1;
                    r.status = peek(q, 0, t);
                end
                ACT_REQ_POP: begin
                    q        = requestor_queue(c.sel, c.rt);
                    has_q    = 1'b1;
                    r.status = pop(q);
                end
                ACT_SLOT_PEEK, ACT_SIZES: begin
                    if (c.act == ACT_SIZES && !layout_by_requestor) begin
                        q     = int'(c.crit);
                        has_q = 1'b1;
                    end else begin
                        // size query on an empty list lists every requestor
                        if (c.act == ACT_SIZES && order_len == 0) begin
                            foreach (order_ids[i]) order_ids[i] = sel_t'(i);
                            order_len = NUM_REQUESTORS;
                        end
                        if (int'(c.sel) >= order_len) begin
                            r.status = ST_BEYOND;
                        end else begin
                            q     = requestor_queue(order_ids[c.sel], c.rt);
                            has_q = 1'b1;
                            if (c.act == ACT_SLOT_PEEK)
                                r.status = peek(q, int'(c.pos), t);
                        end
                    end
                end
                ACT_GEN_POP: begin
                    q        = int'(selected_critical);
                    has_q    = 1'b1;
                    r.status = pop(q);
                end
            endcase
            r.tag    = t;
            r.qcount = has_q ? qcount_t'(fill[q]) : '0;
            r.rcount = rcount_t'(order_len);
            return r;
        endfunction

        function void note_command(command_t c);
            expected_results.insert(expected_results.size(), predict(c));
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data);
            if (expected_results.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", data));
                return;
            end
            want = expected_results.pop_front();
            if (got.tag !== want.tag)
                report($sformatf("out_tag expected %h got %h", want.tag, got.tag));
            if (got.qcount !== want.qcount)
                report($sformatf("queue_count expected %0d got %0d",
                                 want.qcount, got.qcount));
            if (got.rcount !== want.rcount)
                report($sformatf("requestor_count expected %0d got %0d",
                                 want.rcount, got.rcount));
            if (got.status !== want.status)
                report($sformatf("status expected %s got %0d",
                                 want.status.name(), got.status));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Block under test
    // -----------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;

    cmd_queue_scoreboard sb;
    // while set, neither side idles: back-to-back transfers
    bit quiet_stretch;
    int cycle_count;

    memory_command_multi_queue DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic int idle_cycles();
        return quiet_stretch ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic command_t make_command(action_t act, tag_t tag, int sel,
                                              bit crit, bit rt, int pos);
        command_t c;
        c      = '0;
        c.act  = act;
        c.tag  = tag;
        c.sel  = sel_t'(sel);
        c.crit = crit;
        c.rt   = rt;
        c.pos  = pos_t'(pos);
        return c;
    endfunction

    function automatic command_t random_command();
        return make_command(action_t'($urandom_range(0, 7)), $urandom,
                            $urandom_range(0, 7), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 15));
    endfunction

    // Offer one command; valid is only dropped when a gap is drawn, so it
    // never falls and rises within one time step.
    task automatic send_command(command_t c);
        int gap;
        gap = idle_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(c);
    endtask

    // Drop valid, then hold until every owed result has been transferred
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_layout(logic by_requestor);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= by_requestor;
        do @(posedge aclk); while (!cfg_ready);
        sb.layout_by_requestor = by_requestor;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic in bursts aimed at one queue, so that queues really fill
    // up to the refusal point and drain back to empty, mixed with noise.
    task automatic run_random(int n_items);
        command_t focus;
        command_t c;
        int       done;
        int       mode;
        int       len;
        done = 0;
        while (done < n_items) begin
            focus         = random_command();
            mode          = $urandom_range(0, 9);
            len           = $urandom_range(1, 20);
            quiet_stretch = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len && done < n_items; i++) begin
                c = random_command();
                if (mode < 4) begin
                    // fill: inserts into the focus queue
                    if ($urandom_range(0, 99) < 85) begin
                        c.act  = ACT_INSERT;
                        c.sel  = focus.sel;
                        c.crit = focus.crit;
                        c.rt   = focus.rt;
                    end
                end else if (mode < 8) begin
                    // drain: reads, peeks and pops around the focus queue
                    c.act  = action_t'($urandom_range(1, 7));
                    c.sel  = focus.sel;
                    c.crit = focus.crit;
                    c.rt   = focus.rt;
                    if ($urandom_range(0, 1) == 1) c.pos = pos_t'($urandom_range(0, 3));
                end
                send_command(c);
                done++;
            end
        end
        quiet_stretch = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Result side: stall a random number of cycles before each transfer and
    // check every accepted result against the oldest prediction.
    // -----------------------------------------------------------------------
    initial begin
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            stall = idle_cycles();
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    // Watchdog: end the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_memory_command_multi_queue NOT OK");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        bit lazy_order_fill;
        sb            = new();
        quiet_stretch = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        // The order list is filled only once per run, either by the size
        // query on an empty list or by inserts: let the seed pick which.
        lazy_order_fill = $urandom_range(0, 1);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Shared layout: empty queues, extremes, peeks past the tail, and the
        // general pop following the last general front.
        write_layout(1'b0);
        send_command(make_command(ACT_GEN_POP,   '0, 0, 1'b0, 1'b0, 0));
        send_command(make_command(ACT_GEN_FRONT, '0, 0, 1'b0, 1'b0, 0));
        send_command(make_command(ACT_GEN_PEEK,  '0, 0, 1'b1, 1'b0, 0));
        send_command(make_command(ACT_SIZES,     '0, 0, 1'b0, 1'b0, 0));
        send_command(make_command(ACT_SLOT_PEEK, '0, 0, 1'b0, 1'b0, 0));
        send_command(make_command(ACT_REQ_FRONT, '0, 7, 1'b0, 1'b1, 0));
        send_command(make_command(ACT_REQ_POP,   '0, 0, 1'b0, 1'b0, 0));
        send_command(make_command(ACT_INSERT, 32'hFFFF_FFFF, 7, 1'b0, 1'b1, 15));
        send_command(make_command(ACT_INSERT, 32'h0000_0000, 0, 1'b0, 1'b0, 0));
        send_command(make_command(ACT_INSERT, 32'hA5A5_5A5A, 0, 1'b1, 1'b0, 0));
        send_command(make_command(ACT_GEN_PEEK,  '0, 0, 1'b0, 1'b0, 1));
        send_command(make_command(ACT_GEN_PEEK,  '0, 0, 1'b0, 1'b0, 15));
        send_command(make_command(ACT_SIZES,     '0, 0, 1'b1, 1'b0, 0));
        send_command(make_command(ACT_GEN_FRONT, '0, 0, 1'b0, 1'b0, 0));
        repeat (3) send_command(make_command(ACT_GEN_POP, '0, 0, 1'b1, 1'b0, 0));
        drain();

        // Per-requestor layout
        write_layout(1'b1);
        if (lazy_order_fill) begin
            send_command(make_command(ACT_SIZES,     '0, 3, 1'b0, 1'b0, 0));
            send_command(make_command(ACT_SLOT_PEEK, '0, 7, 1'b0, 1'b0, 0));
        end else begin
            // requestor 5 seen twice: listed once
            send_command(make_command(ACT_INSERT, 32'h1234_5678, 5, 1'b0, 1'b1, 0));
            send_command(make_command(ACT_INSERT, 32'h8765_4321, 2, 1'b0, 1'b0, 0));
            send_command(make_command(ACT_INSERT, 32'h0F0F_F0F0, 5, 1'b0, 1'b0, 0));
            send_command(make_command(ACT_SLOT_PEEK, '0, 0, 1'b0, 1'b1, 0));
            send_command(make_command(ACT_SLOT_PEEK, '0, 2, 1'b0, 1'b0, 0));
            send_command(make_command(ACT_SIZES,     '0, 1, 1'b0, 1'b0, 0));
        end
        send_command(make_command(ACT_REQ_FRONT, '0, 5, 1'b0, 1'b1, 0));
        send_command(make_command(ACT_REQ_POP,   '0, 5, 1'b0, 1'b1, 0));
        send_command(make_command(ACT_GEN_POP,   '0, 0, 1'b0, 1'b0, 0));
        drain();

        // Random phases, switching layout between them while idle
        for (int phase = 0; phase < 4; phase++) begin
            write_layout(phase % 2 == 0);
            run_random(100);
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("tb_memory_command_multi_queue OK");
        end else begin
            $display("tb_memory_command_multi_queue NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mcmq_pkg.sv
rtl/core/mcmq_ram.sv
rtl/core/mcmq_ctrl.sv
rtl/core/mcmq_dp.sv
rtl/core/memory_command_multi_queue.sv
tb/tb_memory_command_multi_queue.sv
